### rtl/hts_pkg.sv
// hts_pkg: shared types, constants and sequencer codes for the top-k selector
// used by hts_mem, hts_cmp, hts_ctrl and heap_top_k_smallest_selector
`default_nettype none
package hts_pkg;

  localparam int HEAP_DEPTH_DEF = 16;
  localparam int KEY_W          = 24;
  localparam int TAG_W          = 16;
  localparam int K_W            = 5;
  localparam logic [K_W-1:0] K_RESET = 5'd10;

  typedef struct packed {
    logic [KEY_W-1:0] primary;
    logic [KEY_W-1:0] secondary;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    CMP_X_RD,
    CMP_KIDS,
    CMP_X_CHILD
  } cmp_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_RT_RD,
    ST_RT_CMP,
    ST_DN_CHK,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_DONE,
    ST_EX_CHK,
    ST_EX_SWP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

endpackage
`default_nettype wire

### rtl/hts_mem.sv
// hts_mem: heap storage, one write port and two registered read ports
// depends on hts_pkg
`default_nettype none
module hts_mem #(
  parameter int DEPTH = hts_pkg::HEAP_DEPTH_DEF,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire hts_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]    ra0,
  input  wire logic [AW-1:0]    ra1,
  input  wire logic [AW-1:0]    wa,
  input  wire hts_pkg::entry_t  wd,
  output hts_pkg::entry_t       rd0,
  output hts_pkg::entry_t       rd1
);
  import hts_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd0_r;
  entry_t rd1_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[ra1];
    end
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule
`default_nettype wire

### rtl/hts_cmp.sv
// hts_cmp: shared key comparator with its operand select
// depends on hts_pkg
`default_nettype none
module hts_cmp (
  input  wire hts_pkg::cmp_sel_t sel,
  input  wire hts_pkg::entry_t   x,
  input  wire hts_pkg::entry_t   rd0,
  input  wire hts_pkg::entry_t   rd1,
  input  wire hts_pkg::entry_t   child,
  output logic                   less
);
  import hts_pkg::*;

  entry_t a;
  entry_t b;

  always_comb begin
    unique case (sel)
      CMP_X_RD: begin
        a = x;
        b = rd0;
      end
      CMP_KIDS: begin
        a = rd0;
        b = rd1;
      end
      CMP_X_CHILD: begin
        a = x;
        b = child;
      end
      default: begin
        a = x;
        b = rd0;
      end
    endcase
  end

  // order by primary, then secondary; tag does not take part
  assign less = {a.primary, a.secondary} < {b.primary, b.secondary};

endmodule
`default_nettype wire

### rtl/hts_ctrl.sv
// hts_ctrl: sequencer for heap insert, root replace, in-place sort and emit
// depends on hts_pkg; drives hts_mem and hts_cmp
`default_nettype none
module hts_ctrl #(
  parameter int HEAP_DEPTH = hts_pkg::HEAP_DEPTH_DEF,
  parameter int AW         = 4,
  parameter int IW         = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [hts_pkg::K_W-1:0]    cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire hts_pkg::entry_t            in_entry,
  input  wire logic                       in_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output hts_pkg::entry_t                 out_entry,
  output logic                            out_last,
  output hts_pkg::mem_ctl_t               mem_ctl,
  output logic [AW-1:0]                   ra0,
  output logic [AW-1:0]                   ra1,
  output logic [AW-1:0]                   wa,
  output hts_pkg::entry_t                 wd,
  input  wire hts_pkg::entry_t            rd0,
  input  wire hts_pkg::entry_t            rd1,
  output hts_pkg::cmp_sel_t               cmp_sel,
  output hts_pkg::entry_t                 x,
  output hts_pkg::entry_t                 child,
  input  wire logic                       less
);
  import hts_pkg::*;

  state_t         state_r, state_nxt;
  logic [K_W-1:0] k_r;
  entry_t         x_r, x_nxt;
  entry_t         child_r, child_nxt;
  logic           last_r, last_nxt;
  logic           sorting_r, sorting_nxt;
  logic [IW-1:0]  fill_r, fill_nxt;
  logic [IW-1:0]  size_r, size_nxt;
  logic [IW-1:0]  i_r, i_nxt;
  logic [IW-1:0]  cidx_r, cidx_nxt;
  logic [IW-1:0]  o_r, o_nxt;
  entry_t         out_entry_r, out_entry_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_last_r, out_last_nxt;
  logic [IW-1:0]  k_eff;
  logic [IW:0]    c_idx;
  state_t         dn_ret;

  function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
    logic [IW-1:0] t;
    t = idx - IW'(1);
    return t[AW-1:0];
  endfunction

  always_comb begin
    if (k_r == '0) begin
      k_eff = IW'(1);
    end else if (int'(k_r) > HEAP_DEPTH) begin
      k_eff = IW'(HEAP_DEPTH);
    end else begin
      k_eff = IW'(k_r);
    end
  end

  assign c_idx  = {i_r, 1'b0};
  assign dn_ret = sorting_r ? ST_EX_CHK : ST_DONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= K_RESET;
      fill_r      <= '0;
      sorting_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sorting_r   <= sorting_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        k_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    child_r     <= child_nxt;
    last_r      <= last_nxt;
    size_r      <= size_nxt;
    i_r         <= i_nxt;
    cidx_r      <= cidx_nxt;
    o_r         <= o_nxt;
    out_entry_r <= out_entry_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    child_nxt     = child_r;
    last_nxt      = last_r;
    sorting_nxt   = sorting_r;
    fill_nxt      = fill_r;
    size_nxt      = size_r;
    i_nxt         = i_r;
    cidx_nxt      = cidx_r;
    o_nxt         = o_r;
    out_entry_nxt = out_entry_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    mem_ctl       = '0;
    ra0           = to_addr(i_r);
    ra1           = to_addr(i_r);
    wa            = to_addr(i_r);
    wd            = x_r;
    cmp_sel       = CMP_X_RD;
    in_ready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x_nxt    = in_entry;
          last_nxt = in_last;
          if (fill_r < k_eff) begin
            fill_nxt  = fill_r + IW'(1);
            i_nxt     = fill_r + IW'(1);
            state_nxt = ST_UP_CHK;
          end else begin
            state_nxt = ST_RT_RD;
          end
        end
      end
      ST_UP_CHK: begin
        if (i_r == IW'(1)) begin
          mem_ctl.wr_en = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          ra0           = to_addr(i_r >> 1);
          state_nxt     = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        cmp_sel       = CMP_X_RD;
        mem_ctl.wr_en = 1'b1;
        if (!less) begin
          wd        = rd0;
          i_nxt     = i_r >> 1;
          state_nxt = ST_UP_CHK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RT_RD: begin
        mem_ctl.rd_en = 1'b1;
        ra0           = to_addr(IW'(1));
        state_nxt     = ST_RT_CMP;
      end
      ST_RT_CMP: begin
        cmp_sel = CMP_X_RD;
        if (less) begin
          i_nxt     = IW'(1);
          size_nxt  = fill_r;
          state_nxt = ST_DN_CHK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DN_CHK: begin
        if (c_idx <= {1'b0, size_r}) begin
          mem_ctl.rd_en = 1'b1;
          ra0           = to_addr(c_idx[IW-1:0]);
          ra1           = c_idx[AW-1:0];
          cidx_nxt      = c_idx[IW-1:0];
          state_nxt     = ST_DN_SEL;
        end else begin
          mem_ctl.wr_en = 1'b1;
          state_nxt     = dn_ret;
        end
      end
      ST_DN_SEL: begin
        cmp_sel = CMP_KIDS;
        if (cidx_r != size_r && less) begin
          child_nxt = rd1;
          cidx_nxt  = cidx_r + IW'(1);
        end else begin
          child_nxt = rd0;
        end
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmp_sel       = CMP_X_CHILD;
        mem_ctl.wr_en = 1'b1;
        if (less) begin
          wd        = child_r;
          i_nxt     = cidx_r;
          state_nxt = ST_DN_CHK;
        end else begin
          state_nxt = dn_ret;
        end
      end
      ST_DONE: begin
        if (last_r) begin
          sorting_nxt = 1'b1;
          size_nxt    = fill_r;
          state_nxt   = ST_EX_CHK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EX_CHK: begin
        if (size_r > IW'(1)) begin
          mem_ctl.rd_en = 1'b1;
          ra0           = to_addr(IW'(1));
          ra1           = to_addr(size_r);
          state_nxt     = ST_EX_SWP;
        end else begin
          o_nxt     = IW'(1);
          state_nxt = ST_OUT_RD;
        end
      end
      ST_EX_SWP: begin
        // old root parks at the tail, tail entry sifts down from the top
        mem_ctl.wr_en = 1'b1;
        wa            = to_addr(size_r);
        wd            = rd0;
        x_nxt         = rd1;
        size_nxt      = size_r - IW'(1);
        i_nxt         = IW'(1);
        state_nxt     = ST_DN_CHK;
      end
      ST_OUT_RD: begin
        mem_ctl.rd_en = 1'b1;
        ra0           = to_addr(o_r);
        state_nxt     = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        out_entry_nxt = rd0;
        out_last_nxt  = (o_r == fill_r);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt    = '0;
            sorting_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end else begin
            o_nxt     = o_r + IW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_entry = out_entry_r;
  assign out_last  = out_last_r;
  assign x         = x_r;
  assign child     = child_r;

endmodule
`default_nettype wire

### rtl/heap_top_k_smallest_selector.sv
// Keeps the k smallest items of a run (k from cfg_wdata, 0 acts as 1, values above
// HEAP_DEPTH act as HEAP_DEPTH) in a max-heap ordered by primary then secondary key,
// both unsigned, and emits them in ascending order after the item marked last. One
// item is in flight at a time and in_ready is low while it is worked on. All heap work
// goes through one two-read, one-write memory and one key comparator, so an append
// climbs the heap level by level, a root replace sifts down level by level, and an item
// that loses to the root is dropped. After the last item the heap is sorted in place
// for the n kept items, and each emitted beat is then held until out_ready. The heap
// needs no clearing after reset.
// depends on hts_pkg, hts_mem, hts_cmp, hts_ctrl
`default_nettype none
module heap_top_k_smallest_selector #(
  parameter int HEAP_DEPTH = hts_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [hts_pkg::K_W-1:0]       cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hts_pkg::KEY_W-1:0]     in_primary_key,
  input  wire logic [hts_pkg::KEY_W-1:0]     in_secondary_key,
  input  wire logic [hts_pkg::TAG_W-1:0]     in_item_tag,
  input  wire logic                          in_last_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [hts_pkg::KEY_W-1:0]          out_primary,
  output logic [hts_pkg::KEY_W-1:0]          out_secondary,
  output logic [hts_pkg::TAG_W-1:0]          out_tag,
  output logic                               out_last
);
  import hts_pkg::*;

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int IW = $clog2(HEAP_DEPTH + 1);

  entry_t    in_entry;
  entry_t    out_entry;
  mem_ctl_t  mem_ctl;
  logic [AW-1:0] ra0, ra1, wa;
  entry_t    wd, rd0, rd1;
  cmp_sel_t  cmp_sel;
  entry_t    x, child;
  logic      less;

  assign in_entry.primary   = in_primary_key;
  assign in_entry.secondary = in_secondary_key;
  assign in_entry.tag       = in_item_tag;

  hts_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .AW         (AW),
    .IW         (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_entry  (in_entry),
    .in_last   (in_last_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_entry (out_entry),
    .out_last  (out_last),
    .mem_ctl   (mem_ctl),
    .ra0       (ra0),
    .ra1       (ra1),
    .wa        (wa),
    .wd        (wd),
    .rd0       (rd0),
    .rd1       (rd1),
    .cmp_sel   (cmp_sel),
    .x         (x),
    .child     (child),
    .less      (less)
  );

  hts_mem #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk (clk),
    .ctl (mem_ctl),
    .ra0 (ra0),
    .ra1 (ra1),
    .wa  (wa),
    .wd  (wd),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  hts_cmp u_cmp (
    .sel   (cmp_sel),
    .x     (x),
    .rd0   (rd0),
    .rd1   (rd1),
    .child (child),
    .less  (less)
  );

  assign out_primary   = out_entry.primary;
  assign out_secondary = out_entry.secondary;
  assign out_tag       = out_entry.tag;

endmodule
`default_nettype wire

### rtl/hts_chk.sv
// hts_chk: port-level checks on the top-k selector, bound to the top level
// depends on hts_pkg
`default_nettype none
module hts_chk (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      in_last_item,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [hts_pkg::KEY_W-1:0] out_primary,
  input wire logic [hts_pkg::TAG_W-1:0] out_tag,
  input wire logic                      out_last
);
  import hts_pkg::*;

  // no result beat while an input beat can be taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // final beat of a run frees the input side
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("run did not close after last beat");

  // an item that does not end a run gives no result
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_item |=> !out_valid)
    else $error("result after non-final item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_primary) && $stable(out_tag))
    else $error("stalled result beat changed");

endmodule

bind heap_top_k_smallest_selector hts_chk u_hts_chk (.*);
`default_nettype wire
